### sv/bmci_pkg.sv
`timescale 1ns / 1ps

package bmci_pkg;

    // request kinds carried in tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // write windows decoded from address bits 15..13
    typedef enum logic [2:0] {
        WIN_0000 = 3'b000,
        WIN_2000 = 3'b001,
        WIN_4000 = 3'b010,
        WIN_6000 = 3'b011,
        WIN_8000 = 3'b100,
        WIN_A000 = 3'b101,
        WIN_C000 = 3'b110,
        WIN_E000 = 3'b111
    } t_win;

    localparam logic [15:0] IRQ_COUNT = 16'h1000;

    // fixed banks in the default layout
    localparam logic [3:0] BANK_FIX_8000 = 4'd4;
    localparam logic [3:0] BANK_FIX_A000 = 4'd5;
    localparam logic [3:0] BANK_FIX_E000 = 4'd7;

    // mode register bits
    localparam int MODE_MIRROR = 0;
    localparam int MODE_PRG16  = 3;
    localparam int MODE_PRG32  = 4;

    typedef struct packed {
        logic        req_type;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
    } t_item;

    typedef struct packed {
        logic [3:0] bank_8000;
        logic [3:0] bank_a000;
        logic [3:0] bank_c000;
        logic [3:0] bank_e000;
        logic       irq_out;
        logic       mirror_horizontal;
    } t_result;

    // bank layout from the mode register and the low bank select
    function automatic t_result bank_map(input logic [7:0] mode,
                                         input logic [2:0] low_sel,
                                         input logic       irq);
        t_result r;
        r.irq_out           = irq;
        r.mirror_horizontal = mode[MODE_MIRROR];
        if (mode[MODE_PRG16] && mode[MODE_PRG32]) begin
            r.bank_8000 = {1'b1, mode[6], 2'b00};
            r.bank_a000 = {1'b1, mode[6], 2'b01};
            r.bank_c000 = {1'b1, mode[6], 2'b10};
            r.bank_e000 = {1'b1, mode[6], 2'b11};
        end else if (mode[MODE_PRG16]) begin
            r.bank_8000 = {1'b1, mode[6:5], 1'b0};
            r.bank_a000 = {1'b1, mode[6:5], 1'b1};
            r.bank_c000 = {1'b1, mode[6:5], 1'b0};
            r.bank_e000 = {1'b1, mode[6:5], 1'b1};
        end else begin
            r.bank_8000 = BANK_FIX_8000;
            r.bank_a000 = BANK_FIX_A000;
            r.bank_c000 = {1'b0, low_sel};
            r.bank_e000 = BANK_FIX_E000;
        end
        return r;
    endfunction

endpackage

### sv/bank_mapper_with_cycle_irq_top.sv
`timescale 1ns / 1ps
// each item passes the input register, then the core decode, then the result register
// throughput: one item per cycle unless stalled, set by the input and result registers
// back pressure on the result side stalls the input side only once both registers hold
// reset (synchronous, active low) clears all mapper state, the mode register,
// the configuration register and both stage valid flags

module bank_mapper_with_cycle_irq_top
    import bmci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // alt_submapper
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // bus_address[15:0], bus_data[23:16]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // bank_8000, bank_a000, bank_c000, bank_e000,
                                        // irq_out[16], mirror_horizontal[17], zero pad
);

    t_item   w_in_item;
    t_item   w_core_item;
    t_result w_core_result;
    t_result w_out_result;
    logic    w_core_valid;
    logic    w_core_ready;

    assign o_cfg_ready = 1'b1;

    assign w_in_item.req_type    = s_axis_tuser;
    assign w_in_item.bus_address = s_axis_tdata[15:0];
    assign w_in_item.bus_data    = s_axis_tdata[23:16];

    // input register
    bmci_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_core_valid),
        .i_ready (w_core_ready),
        .o_item  (w_core_item)
    );

    // mapper state and bank decode
    bmci_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_alt (i_cfg_data),
        .i_advance (w_core_valid && w_core_ready),
        .i_item    (w_core_item),
        .o_result  (w_core_result)
    );

    // result register
    bmci_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_core_valid),
        .o_ready  (w_core_ready),
        .i_result (w_core_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    // pack result fields, first field lowest
    assign m_axis_tdata = {6'b000000,
                           w_out_result.mirror_horizontal,
                           w_out_result.irq_out,
                           w_out_result.bank_e000,
                           w_out_result.bank_c000,
                           w_out_result.bank_a000,
                           w_out_result.bank_8000};

endmodule

### sv/bmci_in_stage.sv
`timescale 1ns / 1ps

module bmci_in_stage
    import bmci_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // free slot or the slot drains this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### sv/bmci_core.sv
`timescale 1ns / 1ps

module bmci_core
    import bmci_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_alt,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic        r_alt;
    logic [2:0]  r_low_sel;
    logic [7:0]  r_mode;
    logic        r_cnt_en;
    logic [15:0] r_count;
    logic        r_pending;
    logic        r_irq_line;

    logic [2:0]  n_low_sel;
    logic [7:0]  n_mode;
    logic        n_cnt_en;
    logic [15:0] n_count;
    logic        n_pending;
    logic        n_irq_line;
    logic [15:0] w_count_inc;
    t_win        w_win;

    assign w_win       = t_win'(i_item.bus_address[15:13]);
    assign w_count_inc = r_count + 16'd1;

    // state update for one write or one tick
    always_comb begin
        n_low_sel  = r_low_sel;
        n_mode     = r_mode;
        n_cnt_en   = r_cnt_en;
        n_count    = r_count;
        n_pending  = r_pending;
        n_irq_line = r_irq_line;
        if (i_item.req_type == REQ_TICK) begin
            if (r_pending) begin
                n_pending  = 1'b0;
                n_irq_line = 1'b1;
            end
            if (r_cnt_en) begin
                n_count = w_count_inc;
                if (w_count_inc == IRQ_COUNT) begin
                    n_pending = 1'b1;
                end
            end
        end else begin
            case (w_win)
                WIN_8000: begin
                    n_cnt_en   = 1'b0;
                    n_count    = '0;
                    n_irq_line = 1'b0;
                end
                WIN_A000: begin
                    n_cnt_en = 1'b1;
                end
                WIN_C000: begin
                    if (r_alt) begin
                        n_mode = i_item.bus_address[7:0];
                    end
                end
                WIN_E000: begin
                    n_low_sel = i_item.bus_data[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    // result from the state after this item
    assign o_result = bank_map(n_mode, n_low_sel, n_irq_line);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt <= 1'b0;
        end else if (i_cfg_we) begin
            r_alt <= i_cfg_alt;
        end
    end

    // mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_sel  <= '0;
            r_mode     <= '0;
            r_cnt_en   <= 1'b0;
            r_count    <= '0;
            r_pending  <= 1'b0;
            r_irq_line <= 1'b0;
        end else if (i_advance) begin
            r_low_sel  <= n_low_sel;
            r_mode     <= n_mode;
            r_cnt_en   <= n_cnt_en;
            r_count    <= n_count;
            r_pending  <= n_pending;
            r_irq_line <= n_irq_line;
        end
    end

    // interrupt rises only out of a pending delay
    a_irq_from_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_irq_line && !$past(r_irq_line)) |-> $past(r_pending))
        else $error("irq raised without pending delay");

    // delay is armed only at the match count
    a_pending_at_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending && !$past(r_pending)) |-> (r_count == IRQ_COUNT))
        else $error("pending delay armed off the match count");

    // count moves only while enabled, or is cleared
    a_count_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_cnt_en) || r_count == '0))
        else $error("counter moved while disabled");

endmodule

### sv/bmci_out_stage.sv
`timescale 1ns / 1ps

module bmci_out_stage
    import bmci_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // result held until its transfer
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

### test/tb_bank_mapper_with_cycle_irq_top.sv
`timescale 1ns / 1ps

module tb_bank_mapper_with_cycle_irq_top;
    import bmci_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PERCENT = 27;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = REQ_WRITE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // mapper state as predicted from the accepted transfers
    logic        alt_mode   = 1'b0;
    logic [2:0]  low_sel    = '0;
    logic [7:0]  mode_reg   = '0;
    logic        cnt_on     = 1'b0;
    logic [15:0] cycle_cnt  = '0;
    logic        irq_armed  = 1'b0;
    logic        irq_level  = 1'b0;

    t_result     bank_maps_due [$];
    int          fail_count     = 0;
    int          result_count   = 0;
    int          stall_cycles   = 0;
    int          sink_hold      = 0;
    bit          steady_traffic = 1'b0;

    bank_mapper_with_cycle_irq_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // apply one request to the predicted state and return the mapping after it
    function automatic t_result mapper_after(input logic kind, input logic [15:0] addr,
                                             input logic [7:0] data);
        t_result r;
        int      base;
        if (kind == REQ_WRITE) begin
            case (t_win'(addr[15:13]))
                WIN_8000: begin
                    cnt_on    = 1'b0;
                    cycle_cnt = '0;
                    irq_level = 1'b0;
                end
                WIN_A000: cnt_on = 1'b1;
                WIN_C000: if (alt_mode) mode_reg = addr[7:0];
                WIN_E000: low_sel = data[2:0];
                default: ;
            endcase
        end else begin
            // a pending delay fires before the count moves on
            if (irq_armed) begin
                irq_armed = 1'b0;
                irq_level = 1'b1;
            end
            if (cnt_on) begin
                cycle_cnt = cycle_cnt + 16'd1;
                if (cycle_cnt == IRQ_COUNT) irq_armed = 1'b1;
            end
        end
        r.irq_out           = irq_level;
        r.mirror_horizontal = mode_reg[MODE_MIRROR];
        if (mode_reg[MODE_PRG16] && mode_reg[MODE_PRG32]) begin
            base        = (2 | (mode_reg >> 6)) * 4;
            r.bank_8000 = 4'(base);
            r.bank_a000 = 4'(base + 1);
            r.bank_c000 = 4'(base + 2);
            r.bank_e000 = 4'(base + 3);
        end else if (mode_reg[MODE_PRG16]) begin
            base        = (4 | (mode_reg >> 5)) * 2;
            r.bank_8000 = 4'(base);
            r.bank_a000 = 4'(base + 1);
            r.bank_c000 = 4'(base);
            r.bank_e000 = 4'(base + 1);
        end else begin
            r.bank_8000 = BANK_FIX_8000;
            r.bank_a000 = BANK_FIX_A000;
            r.bank_c000 = {1'b0, low_sel};
            r.bank_e000 = BANK_FIX_E000;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_bank_map(input logic [23:0] got, input t_result want);
        logic [3:0] got_f  [6];
        logic [3:0] want_f [6];
        string      names  [6];
        names  = '{"bank_8000", "bank_a000", "bank_c000", "bank_e000", "irq_out",
                   "mirror_horizontal"};
        got_f  = '{got[3:0], got[7:4], got[11:8], got[15:12], {3'b000, got[16]},
                   {3'b000, got[17]}};
        want_f = '{want.bank_8000, want.bank_a000, want.bank_c000, want.bank_e000,
                   {3'b000, want.irq_out}, {3'b000, want.mirror_horizontal}};
        for (int i = 0; i < 6; i++) begin
            if (got_f[i] !== want_f[i])
                report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                          result_count, names[i], got_f[i], want_f[i]));
        end
    endtask

    // sample every transfer at the rising edge: results first, then new requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (bank_maps_due.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing expected: %h",
                                              result_count, m_axis_tdata));
                else
                    check_bank_map(m_axis_tdata, bank_maps_due.pop_front());
                result_count++;
            end
            if (s_axis_tvalid && s_axis_tready)
                bank_maps_due.push_back(mapper_after(s_axis_tuser, s_axis_tdata[15:0],
                                                     s_axis_tdata[23:16]));
            if (i_cfg_valid && o_cfg_ready)
                alt_mode = i_cfg_data;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end else begin
                m_axis_tready <= steady_traffic || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // offer one request, return at the falling edge after its transfer
    task automatic send_request(input logic kind, input logic [15:0] addr,
                                input logic [7:0] data);
        int gap;
        gap = 0;
        if (!steady_traffic && $urandom_range(0, 99) < IDLE_PERCENT)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_request(REQ_TICK, 16'($urandom), 8'($urandom));
    endtask

    // wait until every result is back, then let the pipeline settle
    task automatic wait_idle();
        while (bank_maps_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_alt_submapper(input logic value);
        stop_sending();
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random tick or write, the writes mostly aimed at the mapper windows
    task automatic send_random_request(input bit allow_clear);
        logic [15:0] addr;
        logic [2:0]  win;
        addr = 16'($urandom);
        if ($urandom_range(0, 99) < 50) begin
            run_ticks(1);
        end else begin
            if ($urandom_range(0, 99) < 75) begin
                case ($urandom_range(0, 3))
                    0: win = WIN_8000;
                    1: win = WIN_A000;
                    2: win = WIN_C000;
                    default: win = WIN_E000;
                endcase
                addr[15:13] = win;
            end
            if (!allow_clear && t_win'(addr[15:13]) == WIN_8000) addr[15:13] = WIN_A000;
            send_request(REQ_WRITE, addr, 8'($urandom));
        end
    endtask

    // ticks with the counter off, writes to unused windows, mode write without alt
    task automatic test_reset_defaults();
        write_alt_submapper(1'b0);
        run_ticks(3);
        send_request(REQ_WRITE, 16'h0000, 8'hFF);
        send_request(REQ_WRITE, 16'h3FFF, 8'h00);
        send_request(REQ_WRITE, 16'h4ABC, 8'h5A);
        send_request(REQ_WRITE, 16'h7FFF, 8'hFF);
        send_request(REQ_WRITE, 16'hC018, 8'h07);
        send_request(REQ_WRITE, 16'hDFFF, 8'hFF);
        run_ticks(2);
    endtask

    // low bank select in the default layout, data extremes
    task automatic test_bank_select();
        send_request(REQ_WRITE, 16'hE000, 8'h00);
        send_request(REQ_WRITE, 16'hFFFF, 8'hFF);
        send_request(REQ_WRITE, 16'hE123, 8'h05);
        send_request(REQ_WRITE, 16'hF000, 8'hFA);
        send_request(REQ_WRITE, 16'hE000, 8'h02);
    endtask

    // mode register: mirroring, 16K and 32K layouts, bank select under them
    task automatic test_mode_register();
        write_alt_submapper(1'b1);
        send_request(REQ_WRITE, 16'hC001, 8'h00);
        send_request(REQ_WRITE, 16'hC008, 8'hFF);
        send_request(REQ_WRITE, 16'hE000, 8'h03);
        send_request(REQ_WRITE, 16'hD068, 8'h00);
        send_request(REQ_WRITE, 16'hC0E8, 8'h00);
        send_request(REQ_WRITE, 16'hC018, 8'h00);
        send_request(REQ_WRITE, 16'hFFFF, 8'h06);
        send_request(REQ_WRITE, 16'hC058, 8'h00);
        send_request(REQ_WRITE, 16'hDFFF, 8'h00);
        send_request(REQ_WRITE, 16'hC010, 8'h00);
        send_request(REQ_WRITE, 16'hC0D9, 8'h00);
        send_request(REQ_WRITE, 16'hC000, 8'hFF);
    endtask

    // with alt off a mode write must leave the current layout alone
    task automatic test_config_gate();
        send_request(REQ_WRITE, 16'hC019, 8'h00);
        write_alt_submapper(1'b0);
        send_request(REQ_WRITE, 16'hC000, 8'h00);
        send_request(REQ_WRITE, 16'hDFE8, 8'hFF);
        run_ticks(2);
        write_alt_submapper(1'b1);
        send_request(REQ_WRITE, 16'hC000, 8'h00);
    endtask

    // counter reaches its target, interrupt one tick later, clear, pending delay
    task automatic test_irq_counter();
        send_request(REQ_WRITE, 16'h8000, 8'h00);
        send_request(REQ_WRITE, 16'hA000, 8'h00);
        run_ticks(int'(IRQ_COUNT) + 3);
        send_request(REQ_WRITE, 16'h9FFF, 8'hFF);
        run_ticks(2);
        // clear while the delay is pending: it still fires on the next tick
        send_request(REQ_WRITE, 16'hBFFF, 8'h00);
        run_ticks(int'(IRQ_COUNT));
        send_request(REQ_WRITE, 16'h8000, 8'h00);
        run_ticks(3);
        send_request(REQ_WRITE, 16'h8000, 8'h00);
        // count keeps running past the target
        send_request(REQ_WRITE, 16'hA000, 8'h00);
        run_ticks(int'(IRQ_COUNT) + 300);
        send_request(REQ_WRITE, 16'h8000, 8'h00);
    endtask

    // result side held off long enough for the block to refuse input
    task automatic test_output_backpressure();
        sink_hold = 200;
        for (int i = 0; i < 40; i++) send_random_request(1'b1);
    endtask

    // random traffic across several alt settings
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            write_alt_submapper(phase != 1);
            for (int i = 0; i < 650; i++) begin
                steady_traffic = (phase == 0) && (i < 200);
                send_random_request(1'b1);
            end
            steady_traffic = 1'b0;
        end
    endtask

    // counter runs to the interrupt under random writes, then random clears
    task automatic test_irq_random();
        int tick_target;
        int tick_count;
        for (int round = 0; round < 2; round++) begin
            send_request(REQ_WRITE, 16'h8000 | 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
            send_request(REQ_WRITE, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
            tick_target = int'(IRQ_COUNT) + int'($urandom_range(0, 40));
            tick_count  = 0;
            // count only the plain ticks so the target is always reached
            while (tick_count < tick_target) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_random_request(1'b0);
                end else begin
                    run_ticks(1);
                    tick_count++;
                end
            end
            for (int i = 0; i < 60; i++) send_random_request(1'b1);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_bank_select();
        test_mode_register();
        test_config_gate();
        test_irq_counter();
        test_output_backpressure();
        test_random_traffic();
        test_irq_random();
        stop_sending();
        wait_idle();
        if (bank_maps_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", bank_maps_due.size()));
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### bank_mapper_with_cycle_irq_top.f
sv/bmci_pkg.sv
sv/bmci_in_stage.sv
sv/bmci_core.sv
sv/bmci_out_stage.sv
sv/bank_mapper_with_cycle_irq_top.sv
test/tb_bank_mapper_with_cycle_irq_top.sv
